### rtl/core/hbrt_pkg.sv
// Shared types and codes for the button remap table.
package hbrt_pkg;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_EVENT  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic [15:0]        device_id;
        logic [15:0]        control_id;
        logic signed [31:0] window_low;
        logic signed [31:0] window_high;
        logic [15:0]        target_mask;
        logic signed [31:0] event_value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] button_mask;
        logic        status;
    } t_out_item;

    typedef struct packed {
        logic [15:0]        device;
        logic [15:0]        control;
        logic signed [31:0] low;
        logic signed [31:0] high;
        logic [15:0]        mask;
        logic signed [31:0] last_value;
        logic               active;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic add_write;
        logic scan;
        logic scan_finish;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic scan_end;
    } t_stat;

endpackage

### rtl/core/hbrt_datapath.sv
// Remap table storage, scan counters, button mask and result register.
module hbrt_datapath #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  hbrt_pkg::t_cmd     i_cmd,
    output hbrt_pkg::t_stat    o_stat,
    input  hbrt_pkg::t_in_item i_in,
    output hbrt_pkg::t_out_item o_out
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);

    hbrt_pkg::t_entry    r_mem [TABLE_ENTRIES];
    hbrt_pkg::t_entry    r_rd_data;
    hbrt_pkg::t_in_item  r_item;
    hbrt_pkg::t_out_item r_out;

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rd_idx, n_rd_idx;
    logic [CW-1:0] r_keep, n_keep;
    logic [IW-1:0] r_proc_idx;
    logic          r_pend, n_pend;
    logic [15:0]   r_mask, n_mask;
    logic          r_status, n_status;

    logic             w_en;
    logic [IW-1:0]    w_addr;
    hbrt_pkg::t_entry w_data;
    logic             rd_en;
    logic             full;
    logic             hit;
    logic             changed;
    logic             now_in;

    assign full    = (r_count == CW'(TABLE_ENTRIES));
    assign rd_en   = i_cmd.scan && (r_rd_idx < r_count);
    assign hit     = (r_rd_data.device == r_item.device_id) &&
                     (r_rd_data.control == r_item.control_id);
    assign changed = (r_rd_data.last_value != r_item.event_value);
    assign now_in  = ($signed(r_item.event_value) >= $signed(r_rd_data.low)) &&
                     ($signed(r_item.event_value) <= $signed(r_rd_data.high));

    assign o_stat.scan_end = (r_rd_idx == r_count) && !r_pend;
    assign o_out           = r_out;

    always_comb begin
        w_en     = 1'b0;
        w_addr   = r_proc_idx;
        w_data   = r_rd_data;
        n_count  = r_count;
        n_rd_idx = r_rd_idx;
        n_keep   = r_keep;
        n_pend   = r_pend;
        n_mask   = r_mask;
        n_status = r_status;

        if (i_cmd.capture) begin
            n_rd_idx = '0;
            n_keep   = '0;
            n_pend   = 1'b0;
            n_status = 1'b0;
        end

        if (i_cmd.add_write) begin
            if (full) begin
                n_status = 1'b1;
            end else begin
                w_en              = 1'b1;
                w_addr            = r_count[IW-1:0];
                w_data.device     = r_item.device_id;
                w_data.control    = r_item.control_id;
                w_data.low        = r_item.window_low;
                w_data.high       = r_item.window_high;
                w_data.mask       = r_item.target_mask;
                w_data.last_value = '0;
                w_data.active     = 1'b0;
                n_count           = r_count + CW'(1);
            end
        end

        if (i_cmd.scan) begin
            n_pend = rd_en;
            if (rd_en) begin
                n_rd_idx = r_rd_idx + CW'(1);
            end
            if (r_pend) begin
                if (r_item.operation == hbrt_pkg::OP_REMOVE) begin
                    // compaction: survivors move down to the keep pointer
                    if (r_rd_data.device != r_item.device_id) begin
                        w_en   = 1'b1;
                        w_addr = r_keep[IW-1:0];
                        n_keep = r_keep + CW'(1);
                    end
                end else if (hit && changed) begin
                    w_en              = 1'b1;
                    w_addr            = r_proc_idx;
                    w_data.last_value = r_item.event_value;
                    w_data.active     = now_in;
                    if (now_in != r_rd_data.active) begin
                        if (now_in) begin
                            n_mask = r_mask | r_rd_data.mask;
                        end else begin
                            n_mask = r_mask & ~r_rd_data.mask;
                        end
                    end
                end
            end
        end

        if (i_cmd.scan_finish && (r_item.operation == hbrt_pkg::OP_REMOVE)) begin
            n_count = r_keep;
            n_mask  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_idx <= '0;
            r_keep   <= '0;
            r_pend   <= 1'b0;
            r_mask   <= '0;
            r_status <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            r_keep   <= n_keep;
            r_pend   <= n_pend;
            r_mask   <= n_mask;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in;
        end
        if (rd_en) begin
            r_proc_idx <= r_rd_idx[IW-1:0];
        end
        if (i_cmd.out_load) begin
            r_out.button_mask <= r_mask;
            r_out.status      <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_idx[IW-1:0]];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_keep_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan |-> (r_keep <= r_rd_idx))
        else $error("compaction pointer ahead of read pointer");

    a_remove_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.scan_finish && (r_item.operation == hbrt_pkg::OP_REMOVE)) |=> (r_mask == '0))
        else $error("remove did not clear the button mask");

endmodule

### rtl/core/hbrt_ctrl.sv
// Sequencing state machine and result valid flag for the remap table.
module hbrt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_operation,
    output hbrt_pkg::t_cmd  o_cmd,
    input  hbrt_pkg::t_stat i_stat,
    output logic            o_out_valid,
    input  logic            i_out_ready
);

    hbrt_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             accept;

    assign o_in_ready  = (r_state == hbrt_pkg::ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hbrt_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            hbrt_pkg::ST_IDLE: begin
                if (accept) begin
                    o_cmd.capture = 1'b1;
                    unique case (i_operation)
                        hbrt_pkg::OP_ADD:    n_state = hbrt_pkg::ST_ADD;
                        hbrt_pkg::OP_REMOVE: n_state = hbrt_pkg::ST_SCAN;
                        hbrt_pkg::OP_EVENT:  n_state = hbrt_pkg::ST_SCAN;
                        default:             n_state = hbrt_pkg::ST_DONE;
                    endcase
                end
            end
            hbrt_pkg::ST_ADD: begin
                o_cmd.add_write = 1'b1;
                n_state         = hbrt_pkg::ST_DONE;
            end
            hbrt_pkg::ST_SCAN: begin
                if (i_stat.scan_end) begin
                    o_cmd.scan_finish = 1'b1;
                    n_state           = hbrt_pkg::ST_DONE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            hbrt_pkg::ST_DONE: begin
                // hold until the previous result has left the output register
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = hbrt_pkg::ST_IDLE;
                end
            end
            default: n_state = hbrt_pkg::ST_IDLE;
        endcase
        n_out_valid = o_cmd.out_load ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("ready high right after an accepted item");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.add_write, o_cmd.scan,
                  o_cmd.scan_finish, o_cmd.out_load}))
        else $error("more than one datapath command at once");

    a_finish_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.scan_finish |=> (r_state == hbrt_pkg::ST_DONE))
        else $error("scan end did not lead to result stage");

    a_load_makes_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid)
        else $error("result load did not raise valid");

endmodule

### rtl/core/hid_button_remap_table_unit.sv
// Top level of the controller button remap table.
//
// Input channel (i_in_valid / o_in_ready, payload i_in) takes one operation
// item: add mapping, remove device, or button event. Output channel
// (o_out_valid / i_out_ready, payload o_out) returns exactly one item per
// input item: the button mask after the operation and the table-full status.
//
// Sequence: an add goes from acceptance through the add stage to the
// result stage, and the unused operation code goes straight to the result
// stage. Remove and button event walk the stored entries in insertion
// order through the single-port table read, one entry per cycle, and then
// go to the result stage. A new item is taken the cycle after the previous
// result has been loaded into the output register, so the unit works on
// one item at a time.
//
// Reset clears the entry count and the button mask; table contents are not
// cleared, as entries at or beyond the count are never read.
// When the receiver stalls, the result waits in the output register; the
// next item is accepted and worked on, and only its result stage waits.
module hid_button_remap_table_unit #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hbrt_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hbrt_pkg::t_out_item o_out
);

    hbrt_pkg::t_cmd  cmd;
    hbrt_pkg::t_stat stat;

    hbrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_operation (i_in.operation),
        .o_cmd       (cmd),
        .i_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    hbrt_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
